// ===== rtl/core/cvps_pkg.sv =====
// cvps_pkg: types, codes and the factory defaults table of the CV programming store.
// Has no dependencies. Used by cv_programming_store_top.
package cvps_pkg;

  localparam int unsigned CvW      = 8;
  localparam int unsigned CmdW     = 2;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned AddrW    = 14;
  localparam int unsigned BitIdxW  = 3;
  localparam int unsigned SweepW   = 7;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 32;

  typedef logic [CvW-1:0]     cv_t;
  typedef logic [SweepW-1:0]  sweep_t;
  typedef logic [StatusW-1:0] status_t;
  typedef logic [CmdW-1:0]    cmd_t;

  // Commands.
  localparam cmd_t CmdWriteByte  = 2'd0;
  localparam cmd_t CmdVerifyByte = 2'd1;
  localparam cmd_t CmdWriteBit   = 2'd2;
  localparam cmd_t CmdVerifyBit  = 2'd3;

  // Status codes.
  localparam status_t StDone     = 3'd0;
  localparam status_t StLocked   = 3'd1;
  localparam status_t StReserved = 3'd2;
  localparam status_t StInvalid  = 3'd3;
  localparam status_t StMismatch = 3'd4;
  localparam status_t StFactory  = 3'd5;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgVersion  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMakerId  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgFirmware = 2'd2;

  localparam cv_t VersionReset  = 8'd1;
  localparam cv_t MakerIdReset  = 8'd13;
  localparam cv_t FirmwareReset = 8'd1;

  // CV numbers.
  localparam cv_t CvShortAddr = 8'd1;
  localparam cv_t CvVersion   = 8'd7;
  localparam cv_t CvMakerId   = 8'd8;
  localparam cv_t CvKey       = 8'd15;
  localparam cv_t CvLock      = 8'd16;
  localparam cv_t CvLongHi    = 8'd17;
  localparam cv_t CvLongLo    = 8'd18;
  localparam cv_t CvConsist   = 8'd19;
  localparam cv_t CvConfig    = 8'd29;
  localparam cv_t CvFirmware  = 8'd58;
  localparam cv_t LastCv      = 8'd106;
  localparam cv_t SpeedFirst  = 8'd67;
  localparam cv_t SpeedLast   = 8'd94;
  localparam cv_t MaxShort    = 8'd127;

  localparam cv_t FactoryFull = 8'd8;
  localparam cv_t FactoryKeep = 8'd9;

  localparam int unsigned LongAddrBit = 5;
  localparam cv_t         LongHiMask  = 8'h3F;
  localparam logic [AddrW-1:0] DefaultShortAddr = 14'd3;

  function automatic cv_t factory_byte(input sweep_t idx);
    cv_t v;
    case (idx)
      7'd1:  v = 8'h03;
      7'd2:  v = 8'h01;
      7'd12: v = 8'h02;
      7'd14: v = 8'h03;
      7'd29: v = 8'h06;
      7'd34: v = 8'h03;
      7'd35: v = 8'h04;
      7'd36: v = 8'h08;
      7'd37: v = 8'h10;
      7'd38: v = 8'h04;
      7'd39: v = 8'h08;
      7'd40: v = 8'h10;
      7'd41: v = 8'h20;
      7'd42: v = 8'h40;
      7'd47: v = 8'h01;
      7'd48: v = 8'h01;
      7'd49: v = 8'hFF;
      7'd50: v = 8'hFF;
      7'd52: v = 8'h3E;
      7'd53: v = 8'h02;
      7'd54: v = 8'hFF;
      7'd55: v = 8'hFF;
      7'd57: v = 8'h3E;
      7'd59: v = 8'h01;
      7'd60: v = 8'h64;
      7'd61: v = 8'h32;
      7'd62: v = 8'h18;
      7'd63: v = 8'hFF;
      7'd64: v = 8'h98;
      7'd67: v = 8'h01;
      7'd68: v = 8'h0A;
      7'd69: v = 8'h13;
      7'd70: v = 8'h1D;
      7'd71: v = 8'h26;
      7'd72: v = 8'h30;
      7'd73: v = 8'h39;
      7'd74: v = 8'h42;
      7'd75: v = 8'h4C;
      7'd76: v = 8'h55;
      7'd77: v = 8'h5F;
      7'd78: v = 8'h68;
      7'd79: v = 8'h71;
      7'd80: v = 8'h7B;
      7'd81: v = 8'h84;
      7'd82: v = 8'h8E;
      7'd83: v = 8'h97;
      7'd84: v = 8'hA0;
      7'd85: v = 8'hAA;
      7'd86: v = 8'hB3;
      7'd87: v = 8'hBD;
      7'd88: v = 8'hC6;
      7'd89: v = 8'hCF;
      7'd90: v = 8'hD9;
      7'd91: v = 8'hE2;
      7'd92: v = 8'hEC;
      7'd93: v = 8'hF5;
      7'd94: v = 8'hFF;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/cv_programming_store_top.sv =====
// cv_programming_store_top: service-mode CV store of a decoder, two-port memory plus
// shadow registers for the addressing, lock and consist CVs.
// Depends on cvps_pkg.
//
// One command at a time. The addressed CV is read from the store's synchronous read port
// at acceptance. The command executes and writes back in the next cycle, and the result is
// registered at the end of that execute cycle. A factory reset (write of 8 or 9 to CV8)
// sweeps CV0..CV106 through the store's write port one entry a cycle (a write of 9 leaves
// CV67..CV94 unwritten) before its result. After reset the same sweep loads the defaults;
// no command is accepted until it ends (configuration writes are taken throughout). A new
// command is taken only once the previous result has been consumed.
module cv_programming_store_top #(
  parameter int unsigned STORE_DEPTH = 128
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cvps_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cvps_pkg::CvW-1:0]      cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // cv_number[7:0], data_byte[15:8], bit_level[16], bit_index[19:17], zero fill
  input  logic [cvps_pkg::InDataW-1:0]  s_axis_tdata,
  // cmd[1:0]
  input  logic [cvps_pkg::CmdW-1:0]     s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // ack[0], status[3:1], active_address[17:4], long_address[18],
  // consist_id[26:19], zero fill
  output logic [cvps_pkg::OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP
  } state_e;

  state_e state_q;

  cvps_pkg::cv_t    mem [STORE_DEPTH];
  cvps_pkg::cv_t    rd_q;

  cvps_pkg::cv_t    version_q, maker_q, firmware_q;
  cvps_pkg::cv_t    cv1_q, key_q, lock_q, cv17_q, cv18_q, cv19_q, cv29_q, stash_q;

  cvps_pkg::cmd_t   cmd_q;
  cvps_pkg::cv_t    cv_q, data_q;
  logic             level_q;
  logic [cvps_pkg::BitIdxW-1:0] idx_q;

  cvps_pkg::sweep_t cnt_q;
  logic             factory_q, keep_q;
  logic             out_valid_q, ack_q;
  cvps_pkg::status_t status_q;

  logic             in_accept;
  logic             in_range, reserved, shadowed;
  cvps_pkg::cv_t    cur, base, mask, wr_val;
  cvps_pkg::status_t res_status;
  logic             res_ack, wr_ok, fr_start, fr_keep;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  cvps_pkg::cv_t    mem_wdata, sweep_val;

  logic [cvps_pkg::AddrW-1:0] long_hi, active_addr;
  logic             is_long;

  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && !out_valid_q;

  // Current value of the addressed CV.
  always_comb begin
    shadowed = 1'b1;
    case (cv_q)
      cvps_pkg::CvShortAddr: cur = cv1_q;
      cvps_pkg::CvKey:       cur = key_q;
      cvps_pkg::CvLock:      cur = lock_q;
      cvps_pkg::CvLongHi:    cur = cv17_q;
      cvps_pkg::CvLongLo:    cur = cv18_q;
      cvps_pkg::CvConsist:   cur = cv19_q;
      cvps_pkg::CvConfig:    cur = cv29_q;
      default: begin
        cur      = rd_q;
        shadowed = 1'b0;
      end
    endcase
  end

  always_comb begin
    in_range = (cv_q != '0) && (cv_q <= cvps_pkg::LastCv);
    reserved = !in_range || (cv_q inside {8'd7, 8'd20, 8'd26, 8'd28, 8'd33, 8'd58,
                                          [8'd96:8'd104]});
    mask     = cvps_pkg::cv_t'(1) << idx_q;
    base     = in_range ? cur : '0;
    wr_val   = data_q;
    if (cmd_q == cvps_pkg::CmdWriteBit) begin
      wr_val = level_q ? (base | mask) : (base & ~mask);
    end

    res_status = cvps_pkg::StDone;
    res_ack    = 1'b0;
    wr_ok      = 1'b0;
    fr_start   = 1'b0;
    fr_keep    = 1'b0;
    case (cmd_q)
      cvps_pkg::CmdVerifyByte: begin
        if (!in_range) begin
          res_status = cvps_pkg::StReserved;
        end else if (key_q != '0 && lock_q != '0 && key_q != lock_q) begin
          res_status = cvps_pkg::StLocked;
        end else if (cur == data_q) begin
          res_ack = 1'b1;
        end else begin
          res_status = cvps_pkg::StMismatch;
        end
      end
      cvps_pkg::CmdVerifyBit: begin
        if (!in_range) begin
          res_status = cvps_pkg::StReserved;
        end else if (cur[idx_q] == level_q) begin
          res_ack = 1'b1;
        end else begin
          res_status = cvps_pkg::StMismatch;
        end
      end
      default: begin
        if (lock_q != '0 && lock_q != key_q && cv_q != cvps_pkg::CvKey) begin
          res_status = cvps_pkg::StLocked;
        end else if (reserved) begin
          res_status = cvps_pkg::StReserved;
        end else if (cv_q == cvps_pkg::CvMakerId) begin
          if (wr_val == cvps_pkg::FactoryFull || wr_val == cvps_pkg::FactoryKeep) begin
            fr_start   = 1'b1;
            fr_keep    = (wr_val == cvps_pkg::FactoryKeep);
            res_status = cvps_pkg::StFactory;
            res_ack    = 1'b1;
          end else begin
            res_status = cvps_pkg::StReserved;
          end
        end else if (cv_q == cvps_pkg::CvShortAddr &&
                     (wr_val == '0 || wr_val > cvps_pkg::MaxShort)) begin
          res_status = cvps_pkg::StInvalid;
        end else if (cv_q == cvps_pkg::CvLongLo && stash_q == '0 && wr_val == '0) begin
          res_status = cvps_pkg::StInvalid;
        end else begin
          wr_ok   = 1'b1;
          res_ack = 1'b1;
        end
      end
    endcase
  end

  // Store write port: command write-back or defaults sweep.
  always_comb begin
    case (cnt_q)
      cvps_pkg::sweep_t'(cvps_pkg::CvVersion):
        sweep_val = factory_q ? version_q : cvps_pkg::VersionReset;
      cvps_pkg::sweep_t'(cvps_pkg::CvMakerId):
        sweep_val = factory_q ? maker_q : cvps_pkg::MakerIdReset;
      cvps_pkg::sweep_t'(cvps_pkg::CvFirmware):
        sweep_val = factory_q ? firmware_q : cvps_pkg::FirmwareReset;
      default:
        sweep_val = cvps_pkg::factory_byte(cnt_q);
    endcase
    if (state_q == ST_SWEEP) begin
      mem_we    = !(keep_q && cnt_q >= cvps_pkg::SpeedFirst[cvps_pkg::SweepW-1:0] &&
                    cnt_q <= cvps_pkg::SpeedLast[cvps_pkg::SweepW-1:0]);
      mem_waddr = AW'(cnt_q);
      mem_wdata = sweep_val;
    end else begin
      mem_we    = (state_q == ST_EXEC) && wr_ok && !shadowed;
      mem_waddr = cv_q[AW-1:0];
      mem_wdata = wr_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (in_accept) begin
      rd_q <= mem[s_axis_tdata[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q <= cvps_pkg::VersionReset;
      maker_q   <= cvps_pkg::MakerIdReset;
      firmware_q <= cvps_pkg::FirmwareReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cvps_pkg::CfgVersion:  version_q  <= cfg_data_i;
        cvps_pkg::CfgMakerId:  maker_q    <= cfg_data_i;
        cvps_pkg::CfgFirmware: firmware_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      cnt_q       <= '0;
      factory_q   <= 1'b0;
      keep_q      <= 1'b0;
      out_valid_q <= 1'b0;
      ack_q       <= 1'b0;
      status_q    <= cvps_pkg::StDone;
      cv1_q       <= cvps_pkg::factory_byte(cvps_pkg::sweep_t'(cvps_pkg::CvShortAddr));
      key_q       <= cvps_pkg::factory_byte(cvps_pkg::sweep_t'(cvps_pkg::CvKey));
      lock_q      <= cvps_pkg::factory_byte(cvps_pkg::sweep_t'(cvps_pkg::CvLock));
      cv17_q      <= cvps_pkg::factory_byte(cvps_pkg::sweep_t'(cvps_pkg::CvLongHi));
      cv18_q      <= cvps_pkg::factory_byte(cvps_pkg::sweep_t'(cvps_pkg::CvLongLo));
      cv19_q      <= cvps_pkg::factory_byte(cvps_pkg::sweep_t'(cvps_pkg::CvConsist));
      cv29_q      <= cvps_pkg::factory_byte(cvps_pkg::sweep_t'(cvps_pkg::CvConfig));
      stash_q     <= '0;
      cmd_q       <= cvps_pkg::CmdWriteByte;
      cv_q        <= '0;
      data_q      <= '0;
      level_q     <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            cmd_q   <= s_axis_tuser;
            cv_q    <= s_axis_tdata[7:0];
            data_q  <= s_axis_tdata[15:8];
            level_q <= s_axis_tdata[16];
            idx_q   <= s_axis_tdata[19:17];
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          ack_q    <= res_ack;
          status_q <= res_status;
          if (fr_start) begin
            cv1_q     <= cvps_pkg::factory_byte(cvps_pkg::sweep_t'(cvps_pkg::CvShortAddr));
            key_q     <= cvps_pkg::factory_byte(cvps_pkg::sweep_t'(cvps_pkg::CvKey));
            lock_q    <= cvps_pkg::factory_byte(cvps_pkg::sweep_t'(cvps_pkg::CvLock));
            cv17_q    <= cvps_pkg::factory_byte(cvps_pkg::sweep_t'(cvps_pkg::CvLongHi));
            cv18_q    <= cvps_pkg::factory_byte(cvps_pkg::sweep_t'(cvps_pkg::CvLongLo));
            cv19_q    <= cvps_pkg::factory_byte(cvps_pkg::sweep_t'(cvps_pkg::CvConsist));
            cv29_q    <= cvps_pkg::factory_byte(cvps_pkg::sweep_t'(cvps_pkg::CvConfig));
            stash_q   <= '0;
            cnt_q     <= '0;
            factory_q <= 1'b1;
            keep_q    <= fr_keep;
            state_q   <= ST_SWEEP;
          end else begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
          if (wr_ok) begin
            case (cv_q)
              cvps_pkg::CvShortAddr: begin
                cv1_q                        <= wr_val;
                cv19_q                       <= '0;
                cv29_q[cvps_pkg::LongAddrBit] <= 1'b0;
              end
              cvps_pkg::CvLongLo: begin
                cv17_q <= stash_q;
                cv18_q <= wr_val;
              end
              cvps_pkg::CvLongHi:  stash_q <= wr_val;
              cvps_pkg::CvKey:     key_q   <= wr_val;
              cvps_pkg::CvLock:    lock_q  <= wr_val;
              cvps_pkg::CvConsist: cv19_q  <= wr_val;
              cvps_pkg::CvConfig:  cv29_q  <= wr_val;
              default: ;
            endcase
          end
        end
        ST_SWEEP: begin
          if (cnt_q == cvps_pkg::LastCv[cvps_pkg::SweepW-1:0]) begin
            out_valid_q <= factory_q;
            state_q     <= ST_IDLE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign long_hi     = {cv17_q[5:0] & cvps_pkg::LongHiMask[5:0], cv18_q};
  assign is_long     = cv29_q[cvps_pkg::LongAddrBit] && (long_hi != '0);
  assign active_addr = is_long ? long_hi :
                       (cv1_q == '0) ? cvps_pkg::DefaultShortAddr :
                       {{(cvps_pkg::AddrW-cvps_pkg::CvW){1'b0}}, cv1_q};

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, cv19_q, is_long, active_addr, status_q, ack_q};

`ifndef SYNTHESIS
  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == ST_EXEC)
    else $error("accepted transaction did not enter execute");

  a_sweep_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SWEEP |-> !out_valid_q)
    else $error("result pending during defaults sweep");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (mem_waddr <= AW'(cvps_pkg::LastCv)))
    else $error("store write beyond last CV");

  a_long_needs_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_long |-> cv29_q[cvps_pkg::LongAddrBit])
    else $error("long address active without CV29 bit 5");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// testbench: self-checking bench for cv_programming_store_top, directed table then random
// command streams under varied idling; results checked against typed rows or a CV model.
// Depends on cvps_pkg and cv_programming_store_top.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CycleLimit    = 1_000_000;
  localparam int unsigned RandomPerPhase = 275;
  localparam int unsigned DirCount      = 26;
  localparam int unsigned HotCount      = 15;
  localparam int unsigned DrainCycles   = 20;
  localparam int unsigned HoldCycles    = 300;
  localparam cvps_pkg::cv_t ResvFirst   = 8'd96;
  localparam cvps_pkg::cv_t ResvLast    = 8'd104;
  localparam logic        Typed         = 1'b1;
  localparam logic        Pred          = 1'b0;

  typedef struct packed {
    cvps_pkg::cmd_t cmd;
    cvps_pkg::cv_t  cv;
    cvps_pkg::cv_t  data;
    logic           lvl;
    logic [2:0]     idx;
  } cv_cmd_t;

  typedef struct packed {
    logic                       ack;
    cvps_pkg::status_t          status;
    logic [cvps_pkg::AddrW-1:0] addr;
    logic                       is_long;
    cvps_pkg::cv_t              consist;
  } cv_result_t;

  typedef struct packed {
    cv_cmd_t           cmd;
    logic              typed;
    logic              ack;
    cvps_pkg::status_t status;
  } dir_row_t;

  localparam cvps_pkg::cv_t FactoryImage [0:106] = '{
    8'h00, 8'h03, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h02, 8'h00, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h06, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h03, 8'h04, 8'h08, 8'h10, 8'h04, 8'h08, 8'h10,
    8'h20, 8'h40, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'hFF, 8'hFF,
    8'h00, 8'h3E, 8'h02, 8'hFF, 8'hFF, 8'h00, 8'h3E, 8'h00, 8'h01, 8'h64,
    8'h32, 8'h18, 8'hFF, 8'h98, 8'h00, 8'h00, 8'h01, 8'h0A, 8'h13, 8'h1D,
    8'h26, 8'h30, 8'h39, 8'h42, 8'h4C, 8'h55, 8'h5F, 8'h68, 8'h71, 8'h7B,
    8'h84, 8'h8E, 8'h97, 8'hA0, 8'hAA, 8'hB3, 8'hBD, 8'hC6, 8'hCF, 8'hD9,
    8'hE2, 8'hEC, 8'hF5, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam cvps_pkg::cv_t HotCvs [0:HotCount-1] = '{
    cvps_pkg::CvShortAddr, cvps_pkg::CvVersion, cvps_pkg::CvMakerId, cvps_pkg::CvKey,
    cvps_pkg::CvLock, cvps_pkg::CvLongHi, cvps_pkg::CvLongLo, cvps_pkg::CvConsist,
    cvps_pkg::CvConfig, cvps_pkg::CvFirmware, 8'd0, ResvFirst, cvps_pkg::LastCv, 8'd107,
    8'd255
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [cvps_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [cvps_pkg::CvW-1:0] cfg_data_i;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [cvps_pkg::InDataW-1:0] s_axis_tdata;
  logic [cvps_pkg::CmdW-1:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [cvps_pkg::OutDataW-1:0] m_axis_tdata;

  // bench copy of the decoder state
  cvps_pkg::cv_t cv_image [0:127];
  cvps_pkg::cv_t long_hi_pending;
  cvps_pkg::cv_t cfg_version, cfg_maker, cfg_firmware;

  cv_result_t pending_results [$];
  dir_row_t   dir_tab [0:DirCount-1];
  int err_cnt, n_sent, n_checked, cycle_cnt;
  int status_hits [0:7];
  int tx_idle_pct, rx_stall_pct, rx_hold, rx_quiet, tx_quiet;
  cv_result_t got_res, want_res;

  always #5 clk_i = ~clk_i;

  cv_programming_store_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  function automatic logic cv_valid(input cvps_pkg::cv_t c);
    return c >= 8'd1 && c <= cvps_pkg::LastCv;
  endfunction

  function automatic logic cv_protected(input cvps_pkg::cv_t c);
    return !cv_valid(c) || c == cvps_pkg::CvVersion || c == 8'd20 || c == 8'd26 ||
           c == 8'd28 || c == 8'd33 || c == cvps_pkg::CvFirmware ||
           (c >= ResvFirst && c <= ResvLast);
  endfunction

  function automatic logic lock_engaged();
    return cv_image[cvps_pkg::CvLock] != 8'd0 &&
           cv_image[cvps_pkg::CvLock] != cv_image[cvps_pkg::CvKey];
  endfunction

  function automatic void reload_defaults(input logic keep_speed);
    for (int i = 0; i <= cvps_pkg::LastCv; i++) begin
      if (!(keep_speed && i >= cvps_pkg::SpeedFirst && i <= cvps_pkg::SpeedLast))
        cv_image[i] = FactoryImage[i];
    end
    cv_image[cvps_pkg::CvVersion]  = cfg_version;
    cv_image[cvps_pkg::CvMakerId]  = cfg_maker;
    cv_image[cvps_pkg::CvFirmware] = cfg_firmware;
    long_hi_pending = 8'd0;
  endfunction

  function automatic cvps_pkg::status_t store_write(input cvps_pkg::cv_t c,
                                                    input cvps_pkg::cv_t v,
                                                    output logic ack);
    ack = 1'b0;
    if (lock_engaged() && c != cvps_pkg::CvKey) return cvps_pkg::StLocked;
    if (cv_protected(c)) return cvps_pkg::StReserved;
    if (c == cvps_pkg::CvMakerId) begin
      if (v == cvps_pkg::FactoryFull || v == cvps_pkg::FactoryKeep) begin
        reload_defaults(v == cvps_pkg::FactoryKeep);
        ack = 1'b1;
        return cvps_pkg::StFactory;
      end
      return cvps_pkg::StReserved;
    end
    if (c == cvps_pkg::CvShortAddr) begin
      if (v == 8'd0 || v > cvps_pkg::MaxShort) return cvps_pkg::StInvalid;
      cv_image[cvps_pkg::CvConfig][cvps_pkg::LongAddrBit] = 1'b0;
      cv_image[cvps_pkg::CvConsist] = 8'd0;
      cv_image[cvps_pkg::CvShortAddr] = v;
    end else if (c == cvps_pkg::CvLongLo) begin
      if (long_hi_pending == 8'd0 && v == 8'd0) return cvps_pkg::StInvalid;
      cv_image[cvps_pkg::CvLongHi] = long_hi_pending;
      cv_image[cvps_pkg::CvLongLo] = v;
    end else if (c == cvps_pkg::CvLongHi) begin
      long_hi_pending = v;
    end else begin
      cv_image[c] = v;
    end
    ack = 1'b1;
    return cvps_pkg::StDone;
  endfunction

  function automatic cv_result_t program_cv(input cv_cmd_t c);
    cv_result_t r;
    cvps_pkg::cv_t cur;
    logic ack;
    cvps_pkg::status_t st;
    int a;
    ack = 1'b0;
    case (c.cmd)
      cvps_pkg::CmdWriteByte: st = store_write(c.cv, c.data, ack);
      cvps_pkg::CmdVerifyByte: begin
        if (!cv_valid(c.cv)) st = cvps_pkg::StReserved;
        else if (cv_image[cvps_pkg::CvKey] != 8'd0 && cv_image[cvps_pkg::CvLock] != 8'd0 &&
                 cv_image[cvps_pkg::CvKey] != cv_image[cvps_pkg::CvLock])
          st = cvps_pkg::StLocked;
        else if (cv_image[c.cv] == c.data) begin
          st = cvps_pkg::StDone;
          ack = 1'b1;
        end else st = cvps_pkg::StMismatch;
      end
      cvps_pkg::CmdWriteBit: begin
        cur = cv_valid(c.cv) ? cv_image[c.cv] : 8'd0;
        cur[c.idx] = c.lvl;
        st = store_write(c.cv, cur, ack);
      end
      default: begin
        if (!cv_valid(c.cv)) st = cvps_pkg::StReserved;
        else if (cv_image[c.cv][c.idx] == c.lvl) begin
          st = cvps_pkg::StDone;
          ack = 1'b1;
        end else st = cvps_pkg::StMismatch;
      end
    endcase
    r.ack = ack;
    r.status = st;
    r.is_long = 1'b0;
    a = 0;
    if (cv_image[cvps_pkg::CvConfig][cvps_pkg::LongAddrBit]) begin
      a = ((cv_image[cvps_pkg::CvLongHi] & cvps_pkg::LongHiMask) << 8) |
          cv_image[cvps_pkg::CvLongLo];
      if (a != 0) r.is_long = 1'b1;
    end
    if (!r.is_long) begin
      a = cv_image[cvps_pkg::CvShortAddr];
      if (a == 0) a = cvps_pkg::DefaultShortAddr;
    end
    r.addr = a[cvps_pkg::AddrW-1:0];
    r.consist = cv_image[cvps_pkg::CvConsist];
    return r;
  endfunction

  function automatic cv_cmd_t mk_cmd(input cvps_pkg::cmd_t op, input cvps_pkg::cv_t c,
                                     input cvps_pkg::cv_t d, input logic l,
                                     input logic [2:0] i);
    cv_cmd_t m;
    m.cmd = op;
    m.cv = c;
    m.data = d;
    m.lvl = l;
    m.idx = i;
    return m;
  endfunction

  // Random command biased toward the CVs with side effects; half the time the content
  // is made to match the current store so verifies and address programming get through.
  function automatic cv_cmd_t pick_cmd();
    cv_cmd_t c;
    int r;
    c = mk_cmd(cvps_pkg::cmd_t'($urandom_range(3)), 8'd0, cvps_pkg::cv_t'($urandom),
               1'($urandom_range(1)), 3'($urandom_range(7)));
    r = $urandom_range(99);
    if (r < 40) c.cv = HotCvs[$urandom_range(HotCount-1)];
    else if (r < 85) c.cv = cvps_pkg::cv_t'($urandom_range(cvps_pkg::LastCv, 1));
    else c.cv = cvps_pkg::cv_t'($urandom_range(255));
    if (lock_engaged() && $urandom_range(99) < 25) begin
      c = mk_cmd(cvps_pkg::CmdWriteByte, cvps_pkg::CvKey, cv_image[cvps_pkg::CvLock],
                 1'b0, 3'd0);
    end else if (cv_valid(c.cv) && $urandom_range(1) == 1) begin
      case (c.cmd)
        cvps_pkg::CmdVerifyByte: c.data = cv_image[c.cv];
        cvps_pkg::CmdVerifyBit:  c.lvl = cv_image[c.cv][c.idx];
        cvps_pkg::CmdWriteBit:
          if (c.cv == cvps_pkg::CvConfig) c.idx = 3'(cvps_pkg::LongAddrBit);
        default: begin
          if (c.cv == cvps_pkg::CvMakerId)
            c.data = $urandom_range(1) ? cvps_pkg::FactoryKeep : cvps_pkg::FactoryFull;
          else if (c.cv == cvps_pkg::CvShortAddr)
            c.data = cvps_pkg::cv_t'($urandom_range(cvps_pkg::MaxShort, 1));
        end
      endcase
    end
    return c;
  endfunction

  task automatic send_cmd(input cv_cmd_t c, input logic use_typed,
                          input cv_result_t typed_res);
    cv_result_t r;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, c.idx, c.lvl, c.data, c.cv};
    s_axis_tuser  <= c.cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    r = program_cv(c);
    if (use_typed) r = typed_res;
    pending_results.push_back(r);
    status_hits[r.status]++;
    n_sent++;
  endtask

  task automatic tx_gap(input int n);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic load_registers(input cvps_pkg::cv_t ver, input cvps_pkg::cv_t mkr,
                                input cvps_pkg::cv_t fw);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= cvps_pkg::CfgVersion;
    cfg_data_i <= ver;
    @(posedge clk_i);
    cfg_idx_i  <= cvps_pkg::CfgMakerId;
    cfg_data_i <= mkr;
    @(posedge clk_i);
    cfg_idx_i  <= cvps_pkg::CfgFirmware;
    cfg_data_i <= fw;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_version  = ver;
    cfg_maker    = mkr;
    cfg_firmware = fw;
  endtask

  task automatic run_random(input int ph);
    int r;
    for (int n = 0; n < RandomPerPhase; n++) begin
      if (ph == 0 && n == 100) rx_hold = HoldCycles;
      if (ph == 1 && n == 140) begin
        s_axis_tvalid <= 1'b0;
        wait_drained();
      end
      r = $urandom_range(99);
      if (r < 6) begin
        // long address programming: high byte, low byte, then enable in CV29
        send_cmd(mk_cmd(cvps_pkg::CmdWriteByte, cvps_pkg::CvLongHi,
                        cvps_pkg::cv_t'($urandom), 1'b0, 3'd0), Pred, '0);
        send_cmd(mk_cmd(cvps_pkg::CmdWriteByte, cvps_pkg::CvLongLo,
                        cvps_pkg::cv_t'($urandom), 1'b0, 3'd0), Pred, '0);
        send_cmd(mk_cmd(cvps_pkg::CmdWriteBit, cvps_pkg::CvConfig, 8'd0, 1'b1,
                        3'(cvps_pkg::LongAddrBit)), Pred, '0);
        n += 2;
      end else begin
        send_cmd(pick_cmd(), Pred, '0);
      end
      if (tx_quiet != 0) tx_quiet--;
      else begin
        if ($urandom_range(99) < 3) tx_quiet = 30;
        if ($urandom_range(99) < tx_idle_pct) tx_gap($urandom_range(6, 1));
      end
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_res.ack     = m_axis_tdata[0];
      got_res.status  = m_axis_tdata[3:1];
      got_res.addr    = m_axis_tdata[17:4];
      got_res.is_long = m_axis_tdata[18];
      got_res.consist = m_axis_tdata[26:19];
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: %h", m_axis_tdata);
        err_cnt++;
      end else begin
        want_res = pending_results.pop_front();
        n_checked++;
        if (got_res.ack !== want_res.ack) begin
          $error("ack: expected %0d, got %0d", want_res.ack, got_res.ack);
          err_cnt++;
        end
        if (got_res.status !== want_res.status) begin
          $error("status: expected %0d, got %0d", want_res.status, got_res.status);
          err_cnt++;
        end
        if (got_res.addr !== want_res.addr) begin
          $error("active_address: expected %0d, got %0d", want_res.addr, got_res.addr);
          err_cnt++;
        end
        if (got_res.is_long !== want_res.is_long) begin
          $error("long_address: expected %0d, got %0d", want_res.is_long, got_res.is_long);
          err_cnt++;
        end
        if (got_res.consist !== want_res.consist) begin
          $error("consist_id: expected %0d, got %0d", want_res.consist,
                 got_res.consist);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: random stalls, quiet stretches and one long hold-off
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold != 0) begin
        m_axis_tready <= 1'b0;
        rx_hold = rx_hold - 1;
      end else if (rx_quiet != 0) begin
        m_axis_tready <= 1'b1;
        rx_quiet = rx_quiet - 1;
      end else begin
        if ($urandom_range(99) < 3) rx_quiet = 24;
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  initial begin
    dir_row_t row;
    cv_result_t typed_res;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = cvps_pkg::CfgVersion;
    cfg_data_i = 8'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = cvps_pkg::CmdWriteByte;
    err_cnt = 0;
    n_sent = 0;
    n_checked = 0;
    cycle_cnt = 0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    rx_hold = 0;
    rx_quiet = 0;
    tx_quiet = 0;
    for (int i = 0; i < 8; i++) status_hits[i] = 0;
    cfg_version = cvps_pkg::VersionReset;
    cfg_maker = cvps_pkg::MakerIdReset;
    cfg_firmware = cvps_pkg::FirmwareReset;
    for (int i = 0; i < 128; i++) cv_image[i] = 8'd0;
    reload_defaults(1'b0);

    dir_tab = '{
      '{'{cvps_pkg::CmdVerifyByte, cvps_pkg::CvVersion, 8'd1, 1'b0, 3'd0},
        Typed, 1'b1, cvps_pkg::StDone},
      '{'{cvps_pkg::CmdVerifyByte, cvps_pkg::CvVersion, 8'd0, 1'b0, 3'd0},
        Typed, 1'b0, cvps_pkg::StMismatch},
      '{'{cvps_pkg::CmdVerifyByte, cvps_pkg::CvMakerId, 8'd13, 1'b0, 3'd0},
        Typed, 1'b1, cvps_pkg::StDone},
      '{'{cvps_pkg::CmdVerifyByte, 8'd0, 8'd0, 1'b0, 3'd0},
        Typed, 1'b0, cvps_pkg::StReserved},
      '{'{cvps_pkg::CmdVerifyBit, 8'd107, 8'd0, 1'b1, 3'd7},
        Typed, 1'b0, cvps_pkg::StReserved},
      '{'{cvps_pkg::CmdVerifyBit, cvps_pkg::CvFirmware, 8'd0, 1'b1, 3'd0},
        Typed, 1'b1, cvps_pkg::StDone},
      '{'{cvps_pkg::CmdWriteByte, cvps_pkg::CvVersion, 8'hFF, 1'b0, 3'd0},
        Typed, 1'b0, cvps_pkg::StReserved},
      '{'{cvps_pkg::CmdWriteByte, cvps_pkg::CvShortAddr, 8'd0, 1'b0, 3'd0},
        Typed, 1'b0, cvps_pkg::StInvalid},
      '{'{cvps_pkg::CmdWriteByte, cvps_pkg::CvShortAddr, 8'd128, 1'b0, 3'd0},
        Typed, 1'b0, cvps_pkg::StInvalid},
      '{'{cvps_pkg::CmdWriteByte, cvps_pkg::CvLongLo, 8'd0, 1'b0, 3'd0},
        Typed, 1'b0, cvps_pkg::StInvalid},
      '{'{cvps_pkg::CmdWriteByte, cvps_pkg::CvMakerId, 8'h55, 1'b0, 3'd0},
        Typed, 1'b0, cvps_pkg::StReserved},
      '{'{cvps_pkg::CmdWriteByte, cvps_pkg::CvShortAddr, 8'd127, 1'b0, 3'd0},
        Pred, 1'b0, cvps_pkg::StDone},
      '{'{cvps_pkg::CmdWriteByte, cvps_pkg::CvConsist, 8'hFF, 1'b0, 3'd0},
        Pred, 1'b0, cvps_pkg::StDone},
      '{'{cvps_pkg::CmdWriteByte, cvps_pkg::CvLongHi, 8'hFF, 1'b0, 3'd0},
        Pred, 1'b0, cvps_pkg::StDone},
      '{'{cvps_pkg::CmdWriteByte, cvps_pkg::CvLongLo, 8'hFF, 1'b0, 3'd0},
        Pred, 1'b0, cvps_pkg::StDone},
      '{'{cvps_pkg::CmdWriteBit, cvps_pkg::CvConfig, 8'd0, 1'b1, 3'd5},
        Pred, 1'b0, cvps_pkg::StDone},
      '{'{cvps_pkg::CmdVerifyBit, cvps_pkg::CvConfig, 8'd0, 1'b1, 3'd5},
        Pred, 1'b0, cvps_pkg::StDone},
      '{'{cvps_pkg::CmdWriteByte, cvps_pkg::CvLock, 8'hFF, 1'b0, 3'd0},
        Pred, 1'b0, cvps_pkg::StDone},
      '{'{cvps_pkg::CmdWriteByte, 8'd70, 8'h77, 1'b0, 3'd0},
        Pred, 1'b0, cvps_pkg::StDone},
      '{'{cvps_pkg::CmdWriteByte, cvps_pkg::CvKey, 8'h01, 1'b0, 3'd0},
        Pred, 1'b0, cvps_pkg::StDone},
      '{'{cvps_pkg::CmdVerifyByte, cvps_pkg::CvShortAddr, 8'd127, 1'b0, 3'd0},
        Pred, 1'b0, cvps_pkg::StDone},
      '{'{cvps_pkg::CmdWriteByte, cvps_pkg::CvKey, 8'hFF, 1'b0, 3'd0},
        Pred, 1'b0, cvps_pkg::StDone},
      '{'{cvps_pkg::CmdWriteByte, 8'd70, 8'h77, 1'b0, 3'd0},
        Pred, 1'b0, cvps_pkg::StDone},
      '{'{cvps_pkg::CmdWriteBit, cvps_pkg::CvMakerId, 8'd0, 1'b0, 3'd2},
        Pred, 1'b0, cvps_pkg::StDone},
      '{'{cvps_pkg::CmdVerifyByte, 8'd70, 8'h77, 1'b0, 3'd0},
        Pred, 1'b0, cvps_pkg::StDone},
      '{'{cvps_pkg::CmdWriteByte, cvps_pkg::CvMakerId, cvps_pkg::FactoryFull, 1'b0, 3'd0},
        Pred, 1'b0, cvps_pkg::StDone}
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // typed rows all precede any change of address or consist
    for (int i = 0; i < DirCount; i++) begin
      row = dir_tab[i];
      typed_res.ack = row.ack;
      typed_res.status = row.status;
      typed_res.addr = cvps_pkg::DefaultShortAddr;
      typed_res.is_long = 1'b0;
      typed_res.consist = 8'd0;
      send_cmd(row.cmd, row.typed, typed_res);
    end
    s_axis_tvalid <= 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      case (ph)
        0: load_registers(8'h00, 8'hFF, 8'h00);
        1: load_registers(8'hFF, 8'h00, 8'hFF);
        2: load_registers(cvps_pkg::cv_t'($urandom), cvps_pkg::cv_t'($urandom),
                          cvps_pkg::cv_t'($urandom));
        default: load_registers(cvps_pkg::VersionReset, cvps_pkg::MakerIdReset,
                                cvps_pkg::FirmwareReset);
      endcase
      case (ph)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 51; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 51; end
        default: begin tx_idle_pct = 13; rx_stall_pct = 13; end
      endcase
      run_random(ph);
      s_axis_tvalid <= 1'b0;
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      err_cnt++;
    end

    $display("tb: %0d commands sent, %0d result transactions checked, %0d errors",
             n_sent, n_checked, err_cnt);
    $display("tb: done %0d, locked %0d, refused %0d, bad value %0d, mismatch %0d, resets %0d",
             status_hits[cvps_pkg::StDone], status_hits[cvps_pkg::StLocked],
             status_hits[cvps_pkg::StReserved], status_hits[cvps_pkg::StInvalid],
             status_hits[cvps_pkg::StMismatch], status_hits[cvps_pkg::StFactory]);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
